// File: design/sac_pkg.sv
`default_nettype none

package sac_pkg;

    localparam int DEF_LEVEL_BITS = 8;
    localparam int DEF_CHANNELS   = 2;

    localparam int CODE_W   = 8;
    localparam int ATT_W    = 10;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 8;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 24;

    typedef enum logic [CFG_AW-1:0] {
        CFG_ZERO_CODE       = 3'd0,
        CFG_MAX_CODE        = 3'd1,
        CFG_MIN_CODE        = 3'd2,
        CFG_MUTE_CODE       = 3'd3,
        CFG_READBACK_ENABLE = 3'd4,
        CFG_RETRY_LIMIT     = 3'd5
    } cfg_index_t;

    typedef enum logic {
        ACT_REQUEST = 1'b0,
        ACT_TICK    = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_WRITE_ERR = 2'd3
    } status_t;

    typedef struct packed {
        logic [CODE_W-1:0] zero_code;
        logic [CODE_W-1:0] max_code;
        logic [CODE_W-1:0] min_code;
        logic [CODE_W-1:0] mute_code;
        logic              readback_enable;
        logic [2:0]        retry_limit;
    } cfg_t;

    typedef struct packed {
        action_t           action;
        logic              channel;
        logic [ATT_W-1:0]  attenuation_half_db;
        logic              mute;
        logic              serial_in;
    } item_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        status_t           status;
        logic [ATT_W-1:0]  applied;
    } level_t;

    typedef struct packed {
        logic [ATT_W-1:0]  applied_half_db;
        status_t           status;
        logic              done_res;
        logic              busy_res;
        logic              serial_out;
        logic              strobe_res;
        logic              chip_select_n;
    } result_t;

endpackage

`default_nettype wire

// File: design/sac_level_calc.sv
`default_nettype none

module sac_level_calc (
    input  sac_pkg::cfg_t   cfg,
    input  sac_pkg::item_t  item,
    output sac_pkg::level_t level
);
    import sac_pkg::*;

    logic signed [ATT_W+1:0] diff;
    logic signed [ATT_W+1:0] max_s;
    logic signed [ATT_W+1:0] min_s;
    logic [CODE_W-1:0]       code;
    status_t                 st;

    assign max_s = $signed({4'b0000, cfg.max_code});
    assign min_s = $signed({4'b0000, cfg.min_code});
    assign diff  = $signed({4'b0000, cfg.zero_code})
                 - $signed({{2{item.attenuation_half_db[ATT_W-1]}}, item.attenuation_half_db});

    // overflow test wins when the clamps cross
    always_comb begin
        code = diff[CODE_W-1:0];
        st   = ST_OK;
        if (diff > max_s) begin
            code = cfg.max_code;
            st   = ST_OVERFLOW;
        end else if (diff < min_s) begin
            code = cfg.min_code;
            st   = ST_UNDERFLOW;
        end
    end

    always_comb begin
        if (item.mute) begin
            level.code    = cfg.mute_code;
            level.status  = ST_OK;
            level.applied = '0;
        end else begin
            level.code    = code;
            level.status  = st;
            level.applied = {2'b00, cfg.zero_code} - {2'b00, code};
        end
    end

endmodule

`default_nettype wire

// File: design/sac_sequencer.sv
`default_nettype none

module sac_sequencer #(
    parameter int LEVEL_BITS = sac_pkg::DEF_LEVEL_BITS,
    parameter int CHANNELS   = sac_pkg::DEF_CHANNELS
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               fire,
    input  sac_pkg::item_t    item,
    input  sac_pkg::cfg_t     cfg,
    input  sac_pkg::level_t   level,
    output sac_pkg::result_t  result
);
    import sac_pkg::*;

    localparam int BIT_W = $clog2(LEVEL_BITS);
    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [2:0] {
        PH_IDLE, PH_HIGH1, PH_LOW1, PH_HIGH2, PH_LOW2, PH_DESEL, PH_RESEL
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic [LEVEL_BITS-1:0] levels_reg [CHANNELS];
    logic [LEVEL_BITS-1:0] levels_next [CHANNELS];
    logic [LEVEL_BITS-1:0] capture_reg, capture_next;
    logic [BIT_W-1:0]      bit_idx_reg, bit_idx_next;
    logic [CH_W-1:0]       ch_idx_reg, ch_idx_next;
    logic [2:0]            attempt_reg, attempt_next;
    status_t               pending_reg, pending_next;
    logic [ATT_W-1:0]      applied_reg, applied_next;
    logic                  mismatch_reg, mismatch_next;
    logic                  cs_n_reg, cs_n_next;
    logic                  strobe_reg, strobe_next;
    logic                  sout_reg, sout_next;

    logic [LEVEL_BITS-1:0] sel_level;
    logic                  ch_ok;
    logic                  byte_end;
    logic                  frame_end;
    logic [3:0]            limit;
    logic                  done;
    status_t               st_out;
    logic [ATT_W-1:0]      app_out;

    // channel counter runs from the top channel down, bits MSB first
    always_comb begin
        sel_level = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (ch_idx_reg == CH_W'(i)) begin
                sel_level = levels_reg[i];
            end
        end
    end

    assign ch_ok     = (int'(item.channel) < CHANNELS);
    assign byte_end  = (bit_idx_reg == '0);
    assign frame_end = byte_end && (ch_idx_reg == '0);
    assign limit     = (cfg.retry_limit == 3'd0) ? 4'd1 : {1'b0, cfg.retry_limit};

    always_comb begin
        phase_next    = phase_reg;
        levels_next   = levels_reg;
        capture_next  = capture_reg;
        bit_idx_next  = bit_idx_reg;
        ch_idx_next   = ch_idx_reg;
        attempt_next  = attempt_reg;
        pending_next  = pending_reg;
        applied_next  = applied_reg;
        mismatch_next = mismatch_reg;
        cs_n_next     = cs_n_reg;
        strobe_next   = strobe_reg;
        sout_next     = sout_reg;
        done          = 1'b0;
        st_out        = ST_OK;
        app_out       = '0;

        if (item.action == ACT_REQUEST) begin
            if (phase_reg == PH_IDLE && ch_ok) begin
                for (int i = 0; i < CHANNELS; i++) begin
                    if (int'(item.channel) == i) begin
                        levels_next[i] = LEVEL_BITS'(level.code);
                    end
                end
                pending_next  = level.status;
                applied_next  = level.applied;
                cs_n_next     = 1'b0;
                strobe_next   = 1'b0;
                sout_next     = 1'b0;
                bit_idx_next  = BIT_W'(LEVEL_BITS - 1);
                ch_idx_next   = CH_W'(CHANNELS - 1);
                attempt_next  = '0;
                capture_next  = '0;
                mismatch_next = 1'b0;
                phase_next    = PH_HIGH1;
            end
        end else begin
            case (phase_reg)
                PH_HIGH1, PH_HIGH2: begin
                    sout_next   = sel_level[bit_idx_reg];
                    strobe_next = 1'b1;
                    if (phase_reg == PH_HIGH2) begin
                        capture_next = {capture_reg[LEVEL_BITS-2:0], item.serial_in};
                        phase_next   = PH_LOW2;
                    end else begin
                        phase_next = PH_LOW1;
                    end
                end
                PH_LOW1, PH_LOW2: begin
                    strobe_next = 1'b0;
                    if (byte_end) begin
                        bit_idx_next = BIT_W'(LEVEL_BITS - 1);
                        if (phase_reg == PH_LOW2) begin
                            if (capture_reg != sel_level) begin
                                mismatch_next = 1'b1;
                            end
                            capture_next = '0;
                        end
                    end else begin
                        bit_idx_next = bit_idx_reg - 1'b1;
                    end
                    if (frame_end) begin
                        ch_idx_next = CH_W'(CHANNELS - 1);
                        phase_next  = (phase_reg == PH_LOW1 && cfg.readback_enable)
                                    ? PH_HIGH2 : PH_DESEL;
                    end else begin
                        if (byte_end) begin
                            ch_idx_next = ch_idx_reg - 1'b1;
                        end
                        phase_next = (phase_reg == PH_LOW1) ? PH_HIGH1 : PH_HIGH2;
                    end
                end
                PH_DESEL: begin
                    cs_n_next   = 1'b1;
                    strobe_next = 1'b0;
                    sout_next   = 1'b0;
                    if (mismatch_reg && ({1'b0, attempt_reg} + 4'd1 < limit)) begin
                        attempt_next = attempt_reg + 1'b1;
                        phase_next   = PH_RESEL;
                    end else begin
                        done       = 1'b1;
                        st_out     = mismatch_reg ? ST_WRITE_ERR : pending_reg;
                        app_out    = applied_reg;
                        phase_next = PH_IDLE;
                    end
                end
                PH_RESEL: begin
                    cs_n_next     = 1'b0;
                    strobe_next   = 1'b0;
                    sout_next     = 1'b0;
                    mismatch_next = 1'b0;
                    capture_next  = '0;
                    bit_idx_next  = BIT_W'(LEVEL_BITS - 1);
                    ch_idx_next   = CH_W'(CHANNELS - 1);
                    phase_next    = PH_HIGH1;
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        result.chip_select_n   = cs_n_next;
        result.strobe_res      = strobe_next;
        result.serial_out      = sout_next;
        result.busy_res        = (phase_next != PH_IDLE);
        result.done_res        = done;
        result.status          = st_out;
        result.applied_half_db = app_out;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            for (int i = 0; i < CHANNELS; i++) begin
                levels_reg[i] <= '0;
            end
            capture_reg  <= '0;
            bit_idx_reg  <= BIT_W'(LEVEL_BITS - 1);
            ch_idx_reg   <= CH_W'(CHANNELS - 1);
            attempt_reg  <= '0;
            pending_reg  <= ST_OK;
            applied_reg  <= '0;
            mismatch_reg <= 1'b0;
            cs_n_reg     <= 1'b1;
            strobe_reg   <= 1'b0;
            sout_reg     <= 1'b0;
        end else if (fire) begin
            phase_reg    <= phase_next;
            levels_reg   <= levels_next;
            capture_reg  <= capture_next;
            bit_idx_reg  <= bit_idx_next;
            ch_idx_reg   <= ch_idx_next;
            attempt_reg  <= attempt_next;
            pending_reg  <= pending_next;
            applied_reg  <= applied_next;
            mismatch_reg <= mismatch_next;
            cs_n_reg     <= cs_n_next;
            strobe_reg   <= strobe_next;
            sout_reg     <= sout_next;
        end
    end

endmodule

`default_nettype wire

// File: design/serial_attenuator_controller_unit.sv
// Serial attenuator controller.
// Input beats on the s_ stream are either level requests (s_tuser = 0) or
// serial clock ticks (s_tuser = 1). A request taken while idle sets one
// channel's level code and starts a serial write of all channel levels; each
// tick moves the serial clock by one half-period. Every accepted beat yields
// exactly one result beat on the m_ stream carrying the pin levels after that
// beat, busy, and on the finishing tick done with status and applied
// attenuation. Configuration registers are written through
// cfg_wr_en/cfg_addr/cfg_wdata; the user must write them only while the block
// is idle, which the block does not enforce. Beats pass the input register,
// then the result register, one beat per cycle while m_tready is high; the
// sequencer state is updated in the single logic stage between the registers.
// Reset (synchronous, aresetn low) empties both registers, restores the
// register defaults, clears the level codes and idles the pins (chip select
// high, strobe and data low). When m_tready is low the result register holds
// its beat; the input register still takes one more beat, then s_tready drops.
`default_nettype none

module serial_attenuator_controller_unit #(
    parameter int LEVEL_BITS = sac_pkg::DEF_LEVEL_BITS,
    parameter int CHANNELS   = sac_pkg::DEF_CHANNELS
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    // tdata: channel, attenuation_half_db[9:0], mute, serial_in, zero pad
    input  wire [sac_pkg::S_DATA_W-1:0]  s_tdata,
    // tuser: action
    input  wire                          s_tuser,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    // tdata: chip_select_n, strobe_res, serial_out, busy_res, done_res,
    //        status[1:0], applied_half_db[9:0], zero pad
    output logic [sac_pkg::M_DATA_W-1:0] m_tdata,
    output logic                         m_tvalid,
    input  wire                          m_tready,
    input  wire                          cfg_wr_en,
    input  wire [sac_pkg::CFG_AW-1:0]    cfg_addr,
    input  wire [sac_pkg::CFG_DW-1:0]    cfg_wdata
);
    import sac_pkg::*;

    cfg_t    cfg_reg;
    item_t   in_item_reg;
    logic    in_vld_reg;
    logic    m_vld_reg;
    result_t res_reg;
    logic    fire;
    level_t  level;
    result_t result;

    assign fire     = in_vld_reg && (!m_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.zero_code       <= 8'd192;
            cfg_reg.max_code        <= 8'd255;
            cfg_reg.min_code        <= 8'd1;
            cfg_reg.mute_code       <= 8'd0;
            cfg_reg.readback_enable <= 1'b1;
            cfg_reg.retry_limit     <= 3'd3;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_ZERO_CODE:       cfg_reg.zero_code       <= cfg_wdata;
                CFG_MAX_CODE:        cfg_reg.max_code        <= cfg_wdata;
                CFG_MIN_CODE:        cfg_reg.min_code        <= cfg_wdata;
                CFG_MUTE_CODE:       cfg_reg.mute_code       <= cfg_wdata;
                CFG_READBACK_ENABLE: cfg_reg.readback_enable <= cfg_wdata[0];
                CFG_RETRY_LIMIT:     cfg_reg.retry_limit     <= cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.action              <= action_t'(s_tuser);
            in_item_reg.channel             <= s_tdata[0];
            in_item_reg.attenuation_half_db <= s_tdata[10:1];
            in_item_reg.mute                <= s_tdata[11];
            in_item_reg.serial_in           <= s_tdata[12];
        end
    end

    sac_level_calc u_calc (
        .cfg   (cfg_reg),
        .item  (in_item_reg),
        .level (level)
    );

    sac_sequencer #(
        .LEVEL_BITS (LEVEL_BITS),
        .CHANNELS   (CHANNELS)
    ) u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .level   (level),
        .result  (result)
    );

    // result beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else if (fire) begin
            m_vld_reg <= 1'b1;
        end else if (m_tready) begin
            m_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= result;
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {7'd0, res_reg.applied_half_db, res_reg.status, res_reg.done_res,
                       res_reg.busy_res, res_reg.serial_out, res_reg.strobe_res,
                       res_reg.chip_select_n};

endmodule

`default_nettype wire
